>>> src/nmit_pkg.sv
// Shared types, constants and float32 helper functions for the normal-matrix block.
package nmit_pkg;

  localparam logic [31:0] QNAN         = 32'h7FC0_0000;
  localparam logic [30:0] THRESH_RESET = 31'h3586_37BD;

  // Latencies of the arithmetic units, in cycles.
  localparam int LAT_MUL = 3;
  localparam int LAT_ADD = 4;
  localparam int NSTEP   = 28;
  localparam int LAT_RCP = NSTEP + 2;

  typedef struct packed {
    logic [31:0] col0_row0;
    logic [31:0] col0_row1;
    logic [31:0] col0_row2;
    logic [31:0] col1_row0;
    logic [31:0] col1_row1;
    logic [31:0] col1_row2;
    logic [31:0] col2_row0;
    logic [31:0] col2_row1;
    logic [31:0] col2_row2;
  } in_t;

  typedef struct packed {
    logic [31:0] out_c0_r0;
    logic [31:0] out_c0_r1;
    logic [31:0] out_c0_r2;
    logic [31:0] out_c1_r0;
    logic [31:0] out_c1_r1;
    logic [31:0] out_c1_r2;
    logic [31:0] out_c2_r0;
    logic [31:0] out_c2_r1;
    logic [31:0] out_c2_r2;
    logic        singular;
  } out_t;

  // Operand class flags.
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fcls_t;

  function automatic fcls_t fp_class(logic [31:0] v);
    fcls_t c;
    c.nan  = (&v[30:23]) && (|v[22:0]);
    c.inf  = (&v[30:23]) && !(|v[22:0]);
    c.zero = (v[30:0] == 31'd0);
    return c;
  endfunction

  // Leading zeros of a 48-bit word (48 when zero).
  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int k = 47; k >= 0; k--) begin
      if (!found) begin
        if (v[k]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. sig[26] is the leading one, value
  // sig/2^26 * 2^(e-127); sig[2] guard, sig[1] round, sig[0] sticky.
  function automatic logic [31:0] fp_round(logic s, logic signed [11:0] e, logic [26:0] sig);
    logic [26:0] sh;
    logic [7:0]  ef;
    logic [11:0] amt;
    logic        st;
    logic        inc;
    logic [30:0] mag;
    sh  = sig;
    ef  = e[7:0];
    amt = 12'd0;
    st  = 1'b0;
    if (e > 12'sd254) begin
      mag = {8'hFF, 23'd0};
    end else begin
      if (e < 12'sd1) begin
        // subnormal: denormalise with sticky
        amt = 12'(12'sd1 - e);
        if (amt > 12'd27) amt = 12'd27;
        for (int k = 0; k < 27; k++) begin
          if (12'(k) < amt) st = st | sig[k];
        end
        sh    = sig >> amt;
        sh[0] = sh[0] | st;
        ef    = 8'd0;
      end
      inc = sh[2] & (sh[1] | sh[0] | sh[3]);
      mag = {ef, sh[25:3]} + {30'd0, inc};
    end
    return {s, mag};
  endfunction

endpackage

>>> src/nmit_delay.sv
// Enabled delay line that keeps operands in step with the float pipeline.
module nmit_delay #(
  parameter int W = 32,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < N; k++) pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

>>> src/nmit_fmul.sv
// Three-stage float32 multiplier: product, normalise, round.
module nmit_fmul import nmit_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  fcls_t             ca, cb;
  logic [7:0]        ea, eb;
  logic              s1_sign_q, s1_nan_q, s1_inf_q, s1_zero_q;
  logic [47:0]       s1_prod_q;
  logic signed [11:0] s1_exp_q;
  logic              s2_sign_q, s2_nan_q, s2_inf_q, s2_zero_q;
  logic signed [11:0] s2_exp_q;
  logic [26:0]       s2_sig_q;
  logic [5:0]        lz;
  logic [47:0]       pn;
  logic [31:0]       y_q;

  assign ca = fp_class(a_i);
  assign cb = fp_class(b_i);
  assign ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= a_i[31] ^ b_i[31];
      s1_nan_q  <= ca.nan | cb.nan | (ca.inf & cb.zero) | (cb.inf & ca.zero);
      s1_inf_q  <= ca.inf | cb.inf;
      s1_zero_q <= ca.zero | cb.zero;
      s1_prod_q <= {|a_i[30:23], a_i[22:0]} * {|b_i[30:23], b_i[22:0]};
      s1_exp_q  <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
    end
  end

  assign lz = lzc48(s1_prod_q);
  assign pn = s1_prod_q << lz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= s1_zero_q;
      s2_exp_q  <= s1_exp_q - $signed({6'd0, lz});
      s2_sig_q  <= {pn[47:22], |pn[21:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s2_nan_q)       y_q <= QNAN;
      else if (s2_inf_q)  y_q <= {s2_sign_q, 8'hFF, 23'd0};
      else if (s2_zero_q) y_q <= {s2_sign_q, 31'd0};
      else                y_q <= fp_round(s2_sign_q, s2_exp_q, s2_sig_q);
    end
  end

  assign y_o = y_q;

endmodule

>>> src/nmit_fadd.sv
// Four-stage float32 adder/subtractor: align, add, normalise, round.
module nmit_fadd import nmit_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        sub_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  fcls_t       ca, cb;
  logic        sa, sb, swap, sl;
  logic [31:0] big, lit;
  logic [7:0]  eb_big, eb_lit, diff;
  logic [26:0] mb, ml, al;
  logic        st;

  logic        s1_sign_q, s1_op_q, s1_nan_q, s1_inf_q, s1_isgn_q, s1_bz_q, s1_zs_q;
  logic [7:0]  s1_exp_q;
  logic [26:0] s1_ma_q, s1_mb_q;
  logic        s2_sign_q, s2_nan_q, s2_inf_q, s2_isgn_q, s2_bz_q, s2_zs_q;
  logic [7:0]  s2_exp_q;
  logic [27:0] s2_sum_q;
  logic        s3_sign_q, s3_nan_q, s3_inf_q, s3_isgn_q, s3_zero_q, s3_zs_q;
  logic signed [11:0] s3_exp_q;
  logic [26:0] s3_sig_q;
  logic [5:0]  lz;
  logic [27:0] rn;
  logic [31:0] y_q;

  assign ca   = fp_class(a_i);
  assign cb   = fp_class(b_i);
  assign sa   = a_i[31];
  assign sb   = b_i[31] ^ sub_i;
  assign swap = a_i[30:0] < b_i[30:0];
  assign big  = swap ? {sb, b_i[30:0]} : {sa, a_i[30:0]};
  assign lit  = swap ? {sa, a_i[30:0]} : {sb, b_i[30:0]};
  assign sl   = lit[31];
  assign eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
  assign eb_lit = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
  assign diff = eb_big - eb_lit;
  assign mb   = {|big[30:23], big[22:0], 3'd0};
  assign ml   = {|lit[30:23], lit[22:0], 3'd0};

  always_comb begin
    st = 1'b0;
    for (int k = 0; k < 27; k++) begin
      if ({24'd0, diff} > 32'(k)) st = st | ml[k];
    end
    if (diff > 8'd26) al = 27'd0;
    else al = ml >> diff;
    al[0] = al[0] | st;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= big[31];
      s1_op_q   <= big[31] ^ sl;
      s1_nan_q  <= ca.nan | cb.nan | (ca.inf & cb.inf & (sa ^ sb));
      s1_inf_q  <= ca.inf | cb.inf;
      s1_isgn_q <= ca.inf ? sa : sb;
      s1_bz_q   <= ca.zero & cb.zero;
      s1_zs_q   <= sa & sb;
      s1_exp_q  <= eb_big;
      s1_ma_q   <= mb;
      s1_mb_q   <= al;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_isgn_q <= s1_isgn_q;
      s2_bz_q   <= s1_bz_q;
      s2_zs_q   <= s1_zs_q;
      s2_exp_q  <= s1_exp_q;
      s2_sum_q  <= s1_op_q ? ({1'b0, s1_ma_q} - {1'b0, s1_mb_q})
                           : ({1'b0, s1_ma_q} + {1'b0, s1_mb_q});
    end
  end

  assign lz = lzc48({s2_sum_q, 20'd0});
  assign rn = s2_sum_q << lz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sign_q <= s2_sign_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_isgn_q <= s2_isgn_q;
      // exact cancellation gives +0 unless both operands were negative zeros (b's sign taken after the subtract flip)
      s3_zero_q <= (s2_sum_q == 28'd0);
      s3_zs_q   <= s2_bz_q & s2_zs_q;
      s3_exp_q  <= $signed({4'd0, s2_exp_q}) - $signed({6'd0, lz}) + 12'sd1;
      s3_sig_q  <= {rn[27:2], |rn[1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s3_nan_q)       y_q <= QNAN;
      else if (s3_inf_q)  y_q <= {s3_isgn_q, 8'hFF, 23'd0};
      else if (s3_zero_q) y_q <= {s3_zs_q, 31'd0};
      else                y_q <= fp_round(s3_sign_q, s3_exp_q, s3_sig_q);
    end
  end

  assign y_o = y_q;

endmodule

>>> src/nmit_frcp.sv
// Float32 reciprocal: restoring division pipelined one quotient bit per stage.
module nmit_frcp import nmit_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  output logic [31:0] y_o
);

  fcls_t      ca;
  logic [7:0] ea;
  logic [23:0] ma;
  logic [5:0] lz;

  logic              sign_q [NSTEP+1];
  logic              nan_q  [NSTEP+1];
  logic              inf_q  [NSTEP+1];
  logic              zero_q [NSTEP+1];
  logic signed [11:0] exp_q [NSTEP+1];
  logic [23:0]       md_q   [NSTEP+1];
  logic [24:0]       rem_q  [NSTEP+1];
  logic [27:0]       quo_q  [NSTEP+1];
  logic [31:0]       y_q;

  logic [27:0]       qf;
  logic              st;
  logic signed [11:0] ef;
  logic [26:0]       sf;

  assign ca = fp_class(a_i);
  assign ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign ma = {|a_i[30:23], a_i[22:0]};
  assign lz = lzc48({ma, 24'd0});

  // normalise the divisor so a subnormal starts with its leading one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q[0] <= a_i[31];
      nan_q[0]  <= ca.nan;
      inf_q[0]  <= ca.inf;
      zero_q[0] <= ca.zero;
      exp_q[0]  <= $signed({4'd0, ea}) - $signed({6'd0, lz});
      md_q[0]   <= ma << lz[4:0];
      rem_q[0]  <= 25'd1 << 23;
      quo_q[0]  <= 28'd0;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [25:0] dif;
    logic        ge;
    assign dif = {1'b0, rem_q[k]} - {2'b00, md_q[k]};
    assign ge  = !dif[25];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sign_q[k+1] <= sign_q[k];
        nan_q[k+1]  <= nan_q[k];
        inf_q[k+1]  <= inf_q[k];
        zero_q[k+1] <= zero_q[k];
        exp_q[k+1]  <= exp_q[k];
        md_q[k+1]   <= md_q[k];
        rem_q[k+1]  <= ge ? {dif[23:0], 1'b0} : {rem_q[k][23:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][26:0], ge};
      end
    end
  end

  assign qf = quo_q[NSTEP];
  assign st = (rem_q[NSTEP] != 25'd0);
  // quotient is 2^27 only for a divisor of exactly a power of two
  assign ef = qf[27] ? (12'sd254 - exp_q[NSTEP]) : (12'sd253 - exp_q[NSTEP]);
  assign sf = qf[27] ? {qf[27:2], qf[1] | qf[0] | st} : {qf[26:1], qf[0] | st};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nan_q[NSTEP])       y_q <= QNAN;
      else if (zero_q[NSTEP]) y_q <= {sign_q[NSTEP], 8'hFF, 23'd0};
      else if (inf_q[NSTEP])  y_q <= {sign_q[NSTEP], 31'd0};
      else                    y_q <= fp_round(sign_q[NSTEP], ef, sf);
    end
  end

  assign y_o = y_q;

endmodule

>>> src/normal_matrix_inverse_transpose.sv
// Normal-matrix block: streams the inverse transpose of 3x3 float32 matrices.
//
// One word carries nine float32 elements stored column by column; one result
// word carries the nine inverse-transpose elements and a singular flag. The
// block takes a new word every cycle while the output is not stalled. For each
// word, 18 products, then cofactor subtraction, three determinant products and
// a subtract and an add give the determinant; a 30-stage pipelined reciprocal
// (one quotient bit per division step) follows, then nine scaling products and
// the output register. Every operation rounds to nearest even with subnormals
// kept; NaN results come out as 0x7FC00000. When the determinant magnitude is
// below the threshold in thr_q the result is all zeros with singular set. The
// whole pipeline holds while a result waits at the output.
module normal_matrix_inverse_transpose import nmit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  localparam int T_COF = LAT_MUL + LAT_ADD;
  localparam int T_DET = T_COF + LAT_MUL + 2 * LAT_ADD;
  localparam int T_RCP = T_DET + LAT_RCP;
  localparam int T_END = T_RCP + LAT_MUL;

  logic        en;
  logic [30:0] thr_q;
  logic [T_END-1:0] vld_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [31:0] a, b, c, d, e, f, g, h, i;
  logic [31:0] ma [18];
  logic [31:0] mb [18];
  logic [31:0] mp [18];
  logic [31:0] cf [10];
  logic [95:0] abc_d;
  logic [31:0] p1, p2, p3, p3_d, dif12, det, rcp;
  logic        sing_now, sing_d;
  logic [31:0] ocof [9];
  logic [31:0] ocof_d [9];
  logic [31:0] res [9];

  // hold everything while the output word is stalled
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign a = in_data_i.col0_row0;
  assign b = in_data_i.col0_row1;
  assign c = in_data_i.col0_row2;
  assign d = in_data_i.col1_row0;
  assign e = in_data_i.col1_row1;
  assign f = in_data_i.col1_row2;
  assign g = in_data_i.col2_row0;
  assign h = in_data_i.col2_row1;
  assign i = in_data_i.col2_row2;

  // product pairs: cofactor k is mp[2k] - mp[2k+1]
  assign ma[0]  = e;  assign mb[0]  = i;
  assign ma[1]  = f;  assign mb[1]  = h;
  assign ma[2]  = d;  assign mb[2]  = i;
  assign ma[3]  = f;  assign mb[3]  = g;
  assign ma[4]  = d;  assign mb[4]  = h;
  assign ma[5]  = e;  assign mb[5]  = g;
  assign ma[6]  = c;  assign mb[6]  = h;
  assign ma[7]  = b;  assign mb[7]  = i;
  assign ma[8]  = a;  assign mb[8]  = i;
  assign ma[9]  = c;  assign mb[9]  = g;
  assign ma[10] = b;  assign mb[10] = g;
  assign ma[11] = a;  assign mb[11] = h;
  assign ma[12] = b;  assign mb[12] = f;
  assign ma[13] = c;  assign mb[13] = e;
  assign ma[14] = c;  assign mb[14] = d;
  assign ma[15] = a;  assign mb[15] = f;
  assign ma[16] = a;  assign mb[16] = e;
  assign ma[17] = b;  assign mb[17] = d;

  for (genvar k = 0; k < 18; k++) begin : g_prod
    nmit_fmul u_mul (.clk_i, .en_i(en), .a_i(ma[k]), .b_i(mb[k]), .y_o(mp[k]));
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    nmit_fadd u_sub (
      .clk_i, .en_i(en), .sub_i(1'b1), .a_i(mp[2*k]), .b_i(mp[2*k+1]), .y_o(cf[k])
    );
  end

  // f*g - d*i rounds on its own, so it is not taken as a negation
  nmit_fadd u_sub_fgdi (
    .clk_i, .en_i(en), .sub_i(1'b1), .a_i(mp[3]), .b_i(mp[2]), .y_o(cf[9])
  );

  nmit_delay #(.W(96), .N(T_COF)) u_dly_abc (
    .clk_i, .en_i(en), .d_i({a, b, c}), .q_o(abc_d)
  );

  nmit_fmul u_mul_p1 (.clk_i, .en_i(en), .a_i(abc_d[95:64]), .b_i(cf[0]), .y_o(p1));
  nmit_fmul u_mul_p2 (.clk_i, .en_i(en), .a_i(abc_d[63:32]), .b_i(cf[1]), .y_o(p2));
  nmit_fmul u_mul_p3 (.clk_i, .en_i(en), .a_i(abc_d[31:0]),  .b_i(cf[2]), .y_o(p3));

  nmit_fadd u_sub_det (
    .clk_i, .en_i(en), .sub_i(1'b1), .a_i(p1), .b_i(p2), .y_o(dif12)
  );

  nmit_delay #(.W(32), .N(LAT_ADD)) u_dly_p3 (
    .clk_i, .en_i(en), .d_i(p3), .q_o(p3_d)
  );

  nmit_fadd u_add_det (
    .clk_i, .en_i(en), .sub_i(1'b0), .a_i(dif12), .b_i(p3_d), .y_o(det)
  );

  // NaN on either side never compares below
  assign sing_now = !(&det[30:23] && |det[22:0]) && !(&thr_q[30:23] && |thr_q[22:0])
                    && (det[30:0] < thr_q);

  nmit_delay #(.W(1), .N(LAT_RCP + LAT_MUL)) u_dly_sing (
    .clk_i, .en_i(en), .d_i(sing_now), .q_o(sing_d)
  );

  nmit_frcp u_rcp (.clk_i, .en_i(en), .a_i(det), .y_o(rcp));

  assign ocof[0] = cf[0];
  assign ocof[1] = cf[9];
  for (genvar k = 2; k < 9; k++) begin : g_ocof
    assign ocof[k] = cf[k];
  end

  for (genvar k = 0; k < 9; k++) begin : g_scale
    nmit_delay #(.W(32), .N(T_RCP - T_COF)) u_dly_cof (
      .clk_i, .en_i(en), .d_i(ocof[k]), .q_o(ocof_d[k])
    );
    nmit_fmul u_mul_r (.clk_i, .en_i(en), .a_i(ocof_d[k]), .b_i(rcp), .y_o(res[k]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[T_END-2:0], in_valid_i};
      out_valid_q <= vld_q[T_END-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_c0_r0 <= sing_d ? 32'd0 : res[0];
      out_q.out_c0_r1 <= sing_d ? 32'd0 : res[1];
      out_q.out_c0_r2 <= sing_d ? 32'd0 : res[2];
      out_q.out_c1_r0 <= sing_d ? 32'd0 : res[3];
      out_q.out_c1_r1 <= sing_d ? 32'd0 : res[4];
      out_q.out_c1_r2 <= sing_d ? 32'd0 : res[5];
      out_q.out_c2_r0 <= sing_d ? 32'd0 : res[6];
      out_q.out_c2_r1 <= sing_d ? 32'd0 : res[7];
      out_q.out_c2_r2 <= sing_d ? 32'd0 : res[8];
      out_q.singular  <= sing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
